>>> rtl/core/cpos_pkg.sv
// ----------------------------------------------------------------------------
// cpos_pkg
// shared types and codes of the closest point on segment block
// ----------------------------------------------------------------------------
package cpos_pkg;

    localparam int COORD_BITS = 32;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [1:0] clamp_t;

    localparam clamp_t CLAMP_INTERIOR = 2'd0;
    localparam clamp_t CLAMP_START    = 2'd1;
    localparam clamp_t CLAMP_END      = 2'd2;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } query_t;

    typedef struct packed {
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
        clamp_t clamp_case;
    } result_t;

endpackage

>>> rtl/core/closest_point_on_segment.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment
// projects a 3d point onto a segment, clamped to the segment ends
// ----------------------------------------------------------------------------
// A query word is taken in every cycle in which start is high; busy is
// always low. Each query gives one result word, shown with done for one
// cycle, in query order. The pipeline holds the restoring divider for the
// ratio, one quotient bit per pipeline stage, plus six stages for
// differences, products, sums, classification, the scaling multiply and
// the final add. The receiver cannot stall the block, so results must be
// taken as they appear.
module closest_point_on_segment #(
    parameter int RATIO_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cpos_pkg::query_t   query,
    output logic               done,
    output cpos_pkg::result_t  result
);

    localparam int CW  = cpos_pkg::COORD_BITS;
    localparam int BW  = CW + 1;
    localparam int PW  = 2 * BW;
    localparam int DW  = PW + 2;
    localparam int MW  = BW + RATIO_BITS + 1;
    localparam int LAT = RATIO_BITS + 6;

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][CW-1:0] e;
        logic [2:0][BW-1:0] b;
        cpos_pkg::clamp_t   cls;
    } geo_t;

    // ---------------- stage 1: differences
    logic                 v1_reg;
    logic [2:0][CW-1:0]   s1_reg, e1_reg;
    logic [2:0][BW-1:0]   b1_reg, d1_reg;
    logic [2:0][CW-1:0]   qp, qs, qe;

    always_comb
    begin
        qp = {query.point_x, query.point_y, query.point_z};
        qs = {query.start_x, query.start_y, query.start_z};
        qe = {query.end_x, query.end_y, query.end_z};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_reg[i] <= qs[i];
            e1_reg[i] <= qe[i];
            b1_reg[i] <= {qe[i][CW-1], qe[i]} - {qs[i][CW-1], qs[i]};
            d1_reg[i] <= {qp[i][CW-1], qp[i]} - {qs[i][CW-1], qs[i]};
        end
    end

    // ---------------- stage 2: products
    logic                          v2_reg;
    logic [2:0][CW-1:0]            s2_reg, e2_reg;
    logic [2:0][BW-1:0]            b2_reg;
    logic signed [PW-1:0]          pbv_reg [3];
    logic signed [PW-1:0]          pbb_reg [3];

    always_ff @(posedge clk)
    begin
        s2_reg <= s1_reg;
        e2_reg <= e1_reg;
        b2_reg <= b1_reg;
        for (int i = 0; i < 3; i++)
        begin
            pbv_reg[i] <= $signed(b1_reg[i]) * $signed(d1_reg[i]);
            pbb_reg[i] <= $signed(b1_reg[i]) * $signed(b1_reg[i]);
        end
    end

    // ---------------- stage 3: dot product and squared length
    logic                 v3_reg;
    logic [2:0][CW-1:0]   s3_reg, e3_reg;
    logic [2:0][BW-1:0]   b3_reg;
    logic signed [DW-1:0] dot3_reg, len3_reg;

    always_ff @(posedge clk)
    begin
        s3_reg   <= s2_reg;
        e3_reg   <= e2_reg;
        b3_reg   <= b2_reg;
        dot3_reg <= DW'(pbv_reg[0]) + DW'(pbv_reg[1]) + DW'(pbv_reg[2]);
        len3_reg <= DW'(pbb_reg[0]) + DW'(pbb_reg[1]) + DW'(pbb_reg[2]);
    end

    // ---------------- stage 4 and divider stages
    // index 0 holds the classified word, index k+1 has k+1 quotient bits
    logic                  dv_reg  [RATIO_BITS+1];
    geo_t                  dg_reg  [RATIO_BITS+1];
    logic [DW-1:0]         rem_reg [RATIO_BITS+1];
    logic [DW-1:0]         len_reg [RATIO_BITS+1];
    logic [RATIO_BITS-1:0] q_reg   [RATIO_BITS+1];
    logic                  nonpos3, ge3;
    cpos_pkg::clamp_t      cls3;

    always_comb
    begin
        nonpos3 = dot3_reg[DW-1] || (dot3_reg == '0);
        ge3     = dot3_reg >= len3_reg;
        if (nonpos3)
            cls3 = cpos_pkg::CLAMP_START;
        else if (ge3)
            cls3 = cpos_pkg::CLAMP_END;
        else
            cls3 = cpos_pkg::CLAMP_INTERIOR;
    end

    always_ff @(posedge clk)
    begin
        dg_reg[0].s   <= s3_reg;
        dg_reg[0].e   <= e3_reg;
        dg_reg[0].b   <= b3_reg;
        dg_reg[0].cls <= cls3;
        rem_reg[0]    <= dot3_reg;
        len_reg[0]    <= len3_reg;
        q_reg[0]      <= '0;
    end

    for (genvar k = 0; k < RATIO_BITS; k++)
    begin : g_div
        logic [DW-1:0] shifted;
        logic          fits;

        always_comb
        begin
            shifted = {rem_reg[k][DW-2:0], 1'b0};
            fits    = shifted >= len_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dg_reg[k+1]  <= dg_reg[k];
            len_reg[k+1] <= len_reg[k];
            rem_reg[k+1] <= fits ? (shifted - len_reg[k]) : shifted;
            q_reg[k+1]   <= {q_reg[k][RATIO_BITS-2:0], fits};
        end
    end

    // ---------------- scaling multiply
    logic                 vm_reg;
    geo_t                 gm_reg;
    logic signed [MW-1:0] m_reg [3];

    always_ff @(posedge clk)
    begin
        gm_reg <= dg_reg[RATIO_BITS];
        for (int i = 0; i < 3; i++)
            m_reg[i] <= $signed(dg_reg[RATIO_BITS].b[i])
                        * $signed({1'b0, q_reg[RATIO_BITS]});
    end

    // ---------------- final add and select
    logic                 done_reg;
    cpos_pkg::result_t    result_reg;
    cpos_pkg::result_t    result_next;
    logic [2:0][CW-1:0]   near;
    logic signed [MW-1:0] step [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            step[i] = m_reg[i] >>> RATIO_BITS;
            case (gm_reg.cls)
                cpos_pkg::CLAMP_START: near[i] = gm_reg.s[i];
                cpos_pkg::CLAMP_END:   near[i] = gm_reg.e[i];
                default:               near[i] = gm_reg.s[i] + step[i][CW-1:0];
            endcase
        end
        result_next.near_x     = near[2];
        result_next.near_y     = near[1];
        result_next.near_z     = near[0];
        result_next.clamp_case = gm_reg.cls;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // valid bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            for (int k = 0; k <= RATIO_BITS; k++)
                dv_reg[k] <= 1'b0;
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int k = 0; k < RATIO_BITS; k++)
                dv_reg[k+1] <= dv_reg[k];
            vm_reg   <= dv_reg[RATIO_BITS];
            done_reg <= vm_reg;
        end
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without a query");

    a_end_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[0] && dg_reg[0].cls == cpos_pkg::CLAMP_END) |-> (len_reg[0] != '0))
        else $error("end clamp on a zero length segment");

    a_start_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.clamp_case == cpos_pkg::CLAMP_START)
        |-> (result.near_x == $past(query.start_x, LAT)))
        else $error("start clamp does not give the start point");

    a_end_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.clamp_case == cpos_pkg::CLAMP_END)
        |-> (result.near_z == $past(query.end_z, LAT)))
        else $error("end clamp does not give the end point");

endmodule
